### design/matrix3_inverse_macros.svh
// Assertion macros used by the matrix3_inverse checker.
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// Check a property on every rising clk_i edge outside reset.
`define M3INV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define M3INV_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### design/m3inv_pkg.sv
// Shared types, constants and cofactor index table of the 3x3 inverter.
package m3inv_pkg;

  localparam int ELEM_W    = 32;
  localparam int DET_OUT_W = 64;
  localparam int N_ELEM    = 9;
  localparam int IDX_W     = 4;
  localparam int COF_W     = 2 * ELEM_W + 1;
  localparam int DET_W     = 3 * ELEM_W + 2;
  localparam int QUO_W     = ELEM_W + 1;
  localparam int CNT_W     = 6;
  localparam int STEP_W    = 3;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_COF,
    ST_DET,
    ST_DMAG,
    ST_DIV,
    ST_ITER,
    ST_DONE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    logic             ld_a;
    logic             ld_b;
    logic             mul_ab;
    logic             cof_init;
    logic             cof_store;
    logic             mul_lo;
    logic             mul_hi;
    logic             add_lo;
    logic             add_hi;
    logic             det_clear;
    logic             det_fin;
    logic             div_load;
    logic             div_init;
    logic             div_step;
    logic             out_load;
    logic             last;
    logic [IDX_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
  } sts_t;

  // Element addresses for cofactor k = m[a]*m[b] - m[c]*m[d] (adjugate order).
  function automatic logic [IDX_W-1:0] cof_idx(input logic [IDX_W-1:0] k,
                                               input logic [1:0] pos);
    logic [4*IDX_W-1:0] row;
    unique case (k)
      4'd0:    row = {4'd4, 4'd8, 4'd5, 4'd7};
      4'd1:    row = {4'd2, 4'd7, 4'd1, 4'd8};
      4'd2:    row = {4'd1, 4'd5, 4'd2, 4'd4};
      4'd3:    row = {4'd5, 4'd6, 4'd3, 4'd8};
      4'd4:    row = {4'd0, 4'd8, 4'd2, 4'd6};
      4'd5:    row = {4'd2, 4'd3, 4'd0, 4'd5};
      4'd6:    row = {4'd3, 4'd7, 4'd4, 4'd6};
      4'd7:    row = {4'd1, 4'd6, 4'd0, 4'd7};
      4'd8:    row = {4'd0, 4'd4, 4'd1, 4'd3};
      default: row = '0;
    endcase
    return row[(3 - pos) * IDX_W +: IDX_W];
  endfunction

endpackage

### design/matrix3_inverse.sv
// Top level of the 3x3 matrix inverter (adjugate over determinant, fixed point).
// Input channel: element_valid_i / element_ready_o carry one signed Q.FRAC_BITS
// element per beat, row-major. Beats are taken one per cycle during loading.
// Output channel: result_valid_o / result_ready_i carry one inverse element per
// beat, row-major, with the determinant, singular, clipped and final_element
// flags; final_element_o marks the ninth beat.
// After the ninth input beat the sequencer forms nine cofactors (on one 32x32
// multiplier and one store read port), the determinant, its magnitude, then
// divides each cofactor with a restoring divider of one quotient bit per cycle.
// The next element's division starts only after the previous result is taken.
// A singular matrix skips the divider.
// Inputs are not taken while results are pending; the block takes one matrix
// at a time. A stalled result holds its beat until the receiver takes it.
// Reset clears the load count and the sequencer; the element store is not
// cleared, since all nine entries are written before any read.
module matrix3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  element_valid_i,
  output logic                                  element_ready_o,
  input  logic signed [m3inv_pkg::ELEM_W-1:0]    element_i,
  output logic                                  result_valid_o,
  input  logic                                  result_ready_i,
  output logic signed [m3inv_pkg::ELEM_W-1:0]    inverse_element_o,
  output logic signed [m3inv_pkg::DET_OUT_W-1:0] determinant_o,
  output logic                                  singular_o,
  output logic                                  clipped_o,
  output logic                                  final_element_o
);
  import m3inv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the phases; hold results until the receiver takes them.
  m3inv_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_valid_i (element_valid_i),
    .element_ready_o (element_ready_o),
    .result_valid_o  (result_valid_o),
    .result_ready_i  (result_ready_i),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // Store, multiply, accumulate and divide on command.
  m3inv_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .element_i         (element_i),
    .inverse_element_o (inverse_element_o),
    .determinant_o     (determinant_o),
    .singular_o        (singular_o),
    .clipped_o         (clipped_o),
    .final_element_o   (final_element_o)
  );

endmodule

### design/m3inv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module m3inv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/m3inv_ctrl.sv
// Sequencer: load, cofactor, determinant, divide and output phases.
module m3inv_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             element_valid_i,
  output logic             element_ready_o,
  output logic             result_valid_o,
  input  logic             result_ready_i,
  input  m3inv_pkg::sts_t  sts_i,
  output m3inv_pkg::cmd_t  cmd_o
);
  import m3inv_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              last_k;

  assign last_k = (k_q == IDX_W'(N_ELEM - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      step_q  <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    k_d             = k_q;
    cnt_d           = cnt_q;
    cmd_o           = '0;
    element_ready_o = 1'b0;
    result_valid_o  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        element_ready_o = 1'b1;
        cmd_o.addr      = k_q;
        if (element_valid_i) begin
          cmd_o.wr_en = 1'b1;
          if (last_k) begin
            k_d     = '0;
            step_d  = '0;
            state_d = ST_COF;
          end else begin
            k_d = k_q + IDX_W'(1);
          end
        end
      end
      ST_COF: begin
        cmd_o.sel = k_q;
        step_d    = step_q + STEP_W'(1);
        unique case (step_q)
          3'd0: begin
            cmd_o.rd_en = 1'b1;
            cmd_o.addr  = cof_idx(k_q, 2'd0);
          end
          3'd1: begin
            cmd_o.ld_a  = 1'b1;
            cmd_o.rd_en = 1'b1;
            cmd_o.addr  = cof_idx(k_q, 2'd1);
          end
          3'd2: begin
            cmd_o.ld_b  = 1'b1;
            cmd_o.rd_en = 1'b1;
            cmd_o.addr  = cof_idx(k_q, 2'd2);
          end
          3'd3: begin
            cmd_o.mul_ab = 1'b1;
            cmd_o.ld_a   = 1'b1;
            cmd_o.rd_en  = 1'b1;
            cmd_o.addr   = cof_idx(k_q, 2'd3);
          end
          3'd4: begin
            cmd_o.ld_b     = 1'b1;
            cmd_o.cof_init = 1'b1;
          end
          3'd5: cmd_o.mul_ab = 1'b1;
          3'd6: begin
            cmd_o.cof_store = 1'b1;
            step_d          = '0;
            if (last_k) begin
              cmd_o.det_clear = 1'b1;
              k_d             = '0;
              state_d         = ST_DET;
            end else begin
              k_d = k_q + IDX_W'(1);
            end
          end
          default: step_d = '0;
        endcase
      end
      ST_DET: begin
        // Expand along row 0: det = sum of m[j] * cofactor[3j].
        cmd_o.sel  = IDX_W'({k_q[IDX_W-2:0], 1'b0}) + k_q;
        cmd_o.addr = k_q;
        step_d     = step_q + STEP_W'(1);
        unique case (step_q)
          3'd0: cmd_o.rd_en  = 1'b1;
          3'd1: cmd_o.ld_a   = 1'b1;
          3'd2: cmd_o.mul_lo = 1'b1;
          3'd3: begin
            cmd_o.add_lo = 1'b1;
            cmd_o.mul_hi = 1'b1;
          end
          3'd4: begin
            cmd_o.add_hi = 1'b1;
            step_d       = '0;
            if (k_q == IDX_W'(2)) begin
              k_d     = '0;
              state_d = ST_DMAG;
            end else begin
              k_d = k_q + IDX_W'(1);
            end
          end
          default: step_d = '0;
        endcase
      end
      ST_DMAG: begin
        cmd_o.det_fin = 1'b1;
        step_d        = '0;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.sel  = k_q;
        cmd_o.last = last_k;
        if (sts_i.det_zero) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_OUT;
        end else if (step_q == '0) begin
          cmd_o.div_load = 1'b1;
          step_d         = STEP_W'(1);
        end else begin
          cmd_o.div_init = 1'b1;
          step_d         = '0;
          cnt_d          = '0;
          state_d        = ST_ITER;
        end
      end
      ST_ITER: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.out_load = 1'b1;
        cmd_o.last     = last_k;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        result_valid_o = 1'b1;
        if (result_ready_i) begin
          step_d = '0;
          if (last_k) begin
            k_d     = '0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + IDX_W'(1);
            state_d = ST_DIV;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

### design/m3inv_dp.sv
// Datapath: element store, cofactor products, determinant, shift-subtract divider.
module m3inv_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  m3inv_pkg::cmd_t                       cmd_i,
  output m3inv_pkg::sts_t                       sts_o,
  input  logic signed [m3inv_pkg::ELEM_W-1:0]    element_i,
  output logic signed [m3inv_pkg::ELEM_W-1:0]    inverse_element_o,
  output logic signed [m3inv_pkg::DET_OUT_W-1:0] determinant_o,
  output logic                                  singular_o,
  output logic                                  clipped_o,
  output logic                                  final_element_o
);
  import m3inv_pkg::*;

  localparam int SHIFT    = 2 * FRAC_BITS;
  localparam int NUM_W    = COF_W + SHIFT;
  localparam int NUM_HI_W = NUM_W - QUO_W;
  localparam int RW       = DET_W + 1;

  logic [ELEM_W-1:0]        rd_data;
  logic signed [ELEM_W-1:0] op_a_q, op_b_q;
  logic signed [COF_W-1:0]  prod_q, cacc_q;
  logic signed [COF_W-1:0]  cof_q [N_ELEM];
  logic signed [COF_W-1:0]  c_sel;
  logic signed [QUO_W-1:0]  c_lo, c_hi;
  logic signed [DET_W-1:0]  det_q, dsh;
  logic [DET_W-1:0]         dmag_q;
  logic                     dneg_q, dzero_q;
  logic [DET_OUT_W-1:0]     det_out_q;
  logic [COF_W-1:0]         cmag_q;
  logic                     cneg_q;
  logic [NUM_W-1:0]         num;
  logic [RW-1:0]            rem_q, r2;
  logic [QUO_W-1:0]         nq_q;
  logic                     ovf_q, ge, qneg;
  logic [ELEM_W-1:0]        val_d;
  logic                     clip_d;
  logic                     sh_pos, sh_neg;

  m3inv_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (N_ELEM)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (cmd_i.addr),
    .wr_data_i (element_i),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (cmd_i.addr),
    .rd_data_o (rd_data)
  );

  assign c_sel = cof_q[cmd_i.sel];
  assign c_lo  = $signed({1'b0, c_sel[ELEM_W-1:0]});
  assign c_hi  = c_sel[COF_W-1:ELEM_W];

  assign dsh    = det_q >>> SHIFT;
  assign sh_pos = ~|dsh[DET_W-1:DET_OUT_W-1];
  assign sh_neg = &dsh[DET_W-1:DET_OUT_W-1];

  assign num = {cmag_q, {SHIFT{1'b0}}};
  assign r2  = {rem_q[RW-2:0], nq_q[QUO_W-1]};
  assign ge  = (r2 >= {1'b0, dmag_q});

  assign qneg = cneg_q ^ dneg_q;

  always_comb begin
    if (qneg) begin
      clip_d = ovf_q | nq_q[QUO_W-1] | (nq_q[ELEM_W-1] & (|nq_q[ELEM_W-2:0]));
      val_d  = clip_d ? {1'b1, {(ELEM_W-1){1'b0}}} : (~nq_q[ELEM_W-1:0]) + ELEM_W'(1);
    end else begin
      clip_d = ovf_q | nq_q[QUO_W-1] | nq_q[ELEM_W-1];
      val_d  = clip_d ? {1'b0, {(ELEM_W-1){1'b1}}} : nq_q[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) op_a_q <= rd_data;
    if (cmd_i.ld_b) op_b_q <= rd_data;
    if (cmd_i.mul_ab) prod_q <= COF_W'(op_a_q * op_b_q);
    if (cmd_i.mul_lo) prod_q <= COF_W'(op_a_q * c_lo);
    if (cmd_i.mul_hi) prod_q <= COF_W'(op_a_q * c_hi);
    if (cmd_i.cof_init) cacc_q <= prod_q;
    if (cmd_i.cof_store) cof_q[cmd_i.sel] <= cacc_q - prod_q;
    if (cmd_i.det_clear) det_q <= '0;
    if (cmd_i.add_lo) det_q <= det_q + DET_W'(prod_q);
    if (cmd_i.add_hi) det_q <= det_q + (DET_W'(prod_q) <<< ELEM_W);
    if (cmd_i.det_fin) begin
      dneg_q  <= det_q[DET_W-1];
      dzero_q <= (det_q == '0);
      dmag_q  <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
      priority if (sh_pos || sh_neg) begin
        det_out_q <= dsh[DET_OUT_W-1:0];
      end else if (det_q[DET_W-1]) begin
        det_out_q <= {1'b1, {(DET_OUT_W-1){1'b0}}};
      end else begin
        det_out_q <= {1'b0, {(DET_OUT_W-1){1'b1}}};
      end
    end
    if (cmd_i.div_load) begin
      cneg_q <= c_sel[COF_W-1];
      cmag_q <= c_sel[COF_W-1] ? COF_W'(-c_sel) : COF_W'(c_sel);
    end
    if (cmd_i.div_init) begin
      // Quotient at or above 2^QUO_W saturates; otherwise QUO_W steps suffice.
      rem_q <= RW'(num[NUM_W-1:QUO_W]);
      ovf_q <= ({{(RW-NUM_HI_W){1'b0}}, num[NUM_W-1:QUO_W]} >= {1'b0, dmag_q});
      nq_q  <= num[QUO_W-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? (r2 - {1'b0, dmag_q}) : r2;
      nq_q  <= {nq_q[QUO_W-2:0], ge};
    end
    if (cmd_i.out_load) begin
      inverse_element_o <= dzero_q ? '0 : val_d;
      clipped_o         <= dzero_q ? 1'b0 : clip_d;
      singular_o        <= dzero_q;
      determinant_o     <= dzero_q ? '0 : det_out_q;
      final_element_o   <= cmd_i.last;
    end
  end

  assign sts_o.det_zero = dzero_q;

endmodule

### design/m3inv_chk.sv
// Port-level checker for matrix3_inverse, bound to the top level.
`include "matrix3_inverse_macros.svh"

module m3inv_chk (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  element_ready_o,
  input logic                                  result_valid_o,
  input logic                                  result_ready_i,
  input logic signed [m3inv_pkg::ELEM_W-1:0]    inverse_element_o,
  input logic                                  singular_o,
  input logic                                  clipped_o
);

  logic zero_beat;
  logic sat_value;
  logic stall;

  assign zero_beat = (inverse_element_o == '0) && !clipped_o;
  assign sat_value = (inverse_element_o == 32'sh7FFF_FFFF) ||
                     (inverse_element_o == 32'sh8000_0000);
  assign stall     = result_valid_o && !result_ready_i;

  // A singular beat carries a zero element and no clip.
  `M3INV_ASSERT(a_singular_zero, result_valid_o && singular_o |-> zero_beat, "singular beat not zero")

  // A clipped beat holds one of the two saturation values.
  `M3INV_ASSERT(a_clip_value, result_valid_o && clipped_o |-> sat_value, "clip not saturated")

  // Loading and emitting never overlap.
  `M3INV_NEVER(a_one_matrix, element_ready_o && result_valid_o, "load during output")

  // A stalled result beat holds.
  `M3INV_ASSERT(a_out_hold, stall |=> result_valid_o && $stable(inverse_element_o), "beat changed")

endmodule

bind matrix3_inverse m3inv_chk u_chk (.*);
